// File: sv/rbbg_pkg.sv
// Package for the random byte block generator: sizes, mixing constants and the
// controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package rbbg_pkg;

  // Largest number of words one request may produce; larger byte counts saturate.
  localparam int MAX_WORDS  = 64;
  localparam int MAX_BYTES  = MAX_WORDS * 8;

  // Field widths fixed by the block's interface.
  localparam int COUNT_W    = 10;
  localparam int WORD_DW    = 64;
  localparam int VBYTES_W   = 4;

  // Internal widths that follow from MAX_WORDS.
  localparam int BYTE_W     = ($clog2(MAX_BYTES + 1) > COUNT_W) ?
                              $clog2(MAX_BYTES + 1) : COUNT_W;
  localparam int WORD_W     = $clog2(MAX_WORDS + 1);

  // SplitMix64 constants.
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

  // Shift amounts.
  localparam int MIX_SH_1 = 30;
  localparam int MIX_SH_2 = 27;
  localparam int MIX_SH_3 = 31;
  localparam int XS_SH_A  = 23;
  localparam int XS_SH_B  = 18;
  localparam int XS_SH_C  = 5;

  localparam logic [VBYTES_W-1:0] FULL_WORD_BYTES = VBYTES_W'(8);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_INIT,    // load mix accumulator from the seed register
    OP_MIX_PRE,      // advance accumulator, first xor-shift
    OP_MUL_LL,       // low x low partial product
    OP_MUL_LH,       // low x high cross term into upper half
    OP_MUL_HL,       // high x low cross term into upper half
    OP_MIX_MID,      // second xor-shift
    OP_MIX_POST_LOW, // final xor-shift, write low half of state
    OP_MIX_POST_HIGH,// final xor-shift, write high half of state
    OP_STEP          // xorshift128+ step, load output register
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic                  use_mul_b;
    logic                  last;
    logic [VBYTES_W-1:0]   tail;
  } dp_cmd_t;

  typedef struct packed {
    logic state_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/rbbg_if.sv
// Handshake channel interfaces: request, result word and seed write.
// Depends on rbbg_pkg.
`timescale 1ns / 1ps
interface rbbg_req_if;
  import rbbg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] byte_count;
  modport source (output valid, output byte_count, input ready);
  modport sink   (input valid, input byte_count, output ready);
endinterface

interface rbbg_word_if;
  import rbbg_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_DW-1:0]  random_word;
  logic [VBYTES_W-1:0] valid_bytes;
  logic                last_word;
  modport source (output valid, output random_word, output valid_bytes,
                  output last_word, input ready);
  modport sink   (input valid, input random_word, input valid_bytes,
                  input last_word, output ready);
endinterface

interface rbbg_seed_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed_value;
  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

// File: sv/random_byte_block_generator.sv
// Top level of the random byte block generator: joins controller and datapath.
// Depends on rbbg_pkg, rbbg_if, rbbg_ctrl and rbbg_datapath.
`timescale 1ns / 1ps
// Each transfer on req carries a byte count; the block answers with enough
// 64-bit words on rsp to cover it (first byte in bits 7:0), marking the final
// word with last_word and giving its number of valid low bytes in valid_bytes.
// Counts above MAX_WORDS*8 bytes are clipped to that; a count of zero yields
// nothing. Words come from xorshift128+ (shifts 23, 18, 5). Whenever the
// 128-bit state is all zero, as after reset, it is first seeded from two
// SplitMix64 outputs of the seed written on cfg. Write cfg only while idle.
// Each word takes a state check and then a generator step, which waits while
// the output register is full and rsp is not ready. Seeding runs on the
// shared 32x32 multiplier, three passes per 64-bit product, two products per
// SplitMix64 output. A new request is taken once the last word of the
// previous one has entered the output register.
module random_byte_block_generator (
  input  logic        clk,
  input  logic        rst,
  rbbg_seed_if.sink   cfg,
  rbbg_req_if.sink    req,
  rbbg_word_if.source rsp
);
  import rbbg_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence requests and mixing steps.
  rbbg_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat)
  );

  // Hold state and seed, compute words, drive the result register.
  rbbg_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .cfg  (cfg),
    .rsp  (rsp)
  );

endmodule

// File: sv/rbbg_datapath.sv
// Datapath: seed register, 128-bit generator state, SplitMix64 mixer with a
// shared 32x32 multiplier, and the output register. Depends on rbbg_pkg.
`timescale 1ns / 1ps
module rbbg_datapath (
  input  logic               clk,
  input  logic               rst,
  input  rbbg_pkg::dp_cmd_t  cmd,
  output rbbg_pkg::dp_stat_t stat,
  rbbg_seed_if.sink          cfg,
  rbbg_word_if.source        rsp
);
  import rbbg_pkg::*;

  logic [63:0] seed;
  logic [63:0] gen_low;
  logic [63:0] gen_high;
  logic [63:0] acc;
  logic [63:0] z;
  logic [63:0] prod;

  logic [63:0] acc_next;
  logic [63:0] mul_k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mix_out;
  logic [63:0] xs_a;
  logic [63:0] xs_high_next;

  logic                out_valid;
  logic [63:0]         out_word;
  logic [VBYTES_W-1:0] out_bytes;
  logic                out_last;

  assign cfg.ready = 1'b1;

  assign acc_next = acc + GOLDEN_GAMMA;
  assign mul_k    = cmd.use_mul_b ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a    = (cmd.op == OP_MUL_HL) ? z[63:32] : z[31:0];
  assign mul_b    = (cmd.op == OP_MUL_LH) ? mul_k[63:32] : mul_k[31:0];
  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign mix_out  = prod ^ (prod >> MIX_SH_3);

  assign xs_a         = gen_low ^ (gen_low << XS_SH_A);
  assign xs_high_next = xs_a ^ gen_high ^ (xs_a >> XS_SH_B) ^ (gen_high >> XS_SH_C);

  assign stat.state_zero = (gen_low == 64'd0) && (gen_high == 64'd0);
  assign stat.out_free   = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= 64'd0;
      gen_low  <= 64'd0;
      gen_high <= 64'd0;
    end else begin
      if (cfg.valid) begin
        seed <= cfg.seed_value;
      end
      case (cmd.op)
        OP_MIX_POST_LOW:  gen_low <= mix_out;
        OP_MIX_POST_HIGH: gen_high <= mix_out;
        OP_STEP: begin
          gen_low  <= gen_high;
          gen_high <= xs_high_next;
        end
        default: ;
      endcase
    end
  end

  // Mixer working registers: no reset needed.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SEED_INIT: acc <= seed;
      OP_MIX_PRE: begin
        acc <= acc_next;
        z   <= acc_next ^ (acc_next >> MIX_SH_1);
      end
      OP_MUL_LL:  prod <= mul_p;
      OP_MUL_LH,
      OP_MUL_HL:  prod[63:32] <= prod[63:32] + mul_p[31:0];
      OP_MIX_MID: z <= prod ^ (prod >> MIX_SH_2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_STEP) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STEP) begin
      out_word  <= xs_high_next + gen_high;
      out_bytes <= cmd.tail;
      out_last  <= cmd.last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;
  assign rsp.valid_bytes = out_bytes;
  assign rsp.last_word   = out_last;

endmodule

// File: sv/rbbg_ctrl.sv
// Controller: takes requests, counts words and sequences seeding, mixing
// multiplies and generator steps. Depends on rbbg_pkg.
`timescale 1ns / 1ps
module rbbg_ctrl (
  input  logic               clk,
  input  logic               rst,
  rbbg_req_if.sink           req,
  output rbbg_pkg::dp_cmd_t  cmd,
  input  rbbg_pkg::dp_stat_t stat
);
  import rbbg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PRE, S_M1LL, S_M1LH, S_M1HL, S_MID,
    S_M2LL, S_M2LH, S_M2HL, S_POST, S_STEP
  } state_t;

  state_t              state;
  logic                second;
  logic [WORD_W-1:0]   words_left;
  logic [VBYTES_W-1:0] tail;

  logic [BYTE_W-1:0]   count_in;
  logic [BYTE_W-1:0]   count_sat;
  logic [BYTE_W:0]     word_sum;
  logic [WORD_W-1:0]   words_req;
  logic [VBYTES_W-1:0] tail_req;
  logic                is_last;

  assign req.ready = (state == S_IDLE);

  // Saturate the count, then round up to whole words.
  assign count_in  = BYTE_W'(req.byte_count);
  assign count_sat = (count_in > BYTE_W'(MAX_BYTES)) ? BYTE_W'(MAX_BYTES) : count_in;
  assign word_sum  = {1'b0, count_sat} + (BYTE_W + 1)'(7);
  assign words_req = word_sum[WORD_W+2:3];
  assign tail_req  = (count_sat[2:0] == 3'd0) ? FULL_WORD_BYTES
                                              : {1'b0, count_sat[2:0]};
  assign is_last   = (words_left == WORD_W'(1));

  always_comb begin
    cmd.op        = OP_NONE;
    cmd.use_mul_b = 1'b0;
    cmd.last      = is_last;
    cmd.tail      = is_last ? tail : FULL_WORD_BYTES;
    case (state)
      S_CHECK: if (stat.state_zero) cmd.op = OP_SEED_INIT;
      S_PRE:   cmd.op = OP_MIX_PRE;
      S_M1LL:  cmd.op = OP_MUL_LL;
      S_M1LH:  cmd.op = OP_MUL_LH;
      S_M1HL:  cmd.op = OP_MUL_HL;
      S_MID:   cmd.op = OP_MIX_MID;
      S_M2LL: begin
        cmd.op        = OP_MUL_LL;
        cmd.use_mul_b = 1'b1;
      end
      S_M2LH: begin
        cmd.op        = OP_MUL_LH;
        cmd.use_mul_b = 1'b1;
      end
      S_M2HL: begin
        cmd.op        = OP_MUL_HL;
        cmd.use_mul_b = 1'b1;
      end
      S_POST:  cmd.op = second ? OP_MIX_POST_HIGH : OP_MIX_POST_LOW;
      S_STEP:  if (stat.out_free) cmd.op = OP_STEP;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      second     <= 1'b0;
      words_left <= '0;
      tail       <= FULL_WORD_BYTES;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid && count_sat != '0) begin
            words_left <= words_req;
            tail       <= tail_req;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          second <= 1'b0;
          state  <= stat.state_zero ? S_PRE : S_STEP;
        end
        S_PRE:  state <= S_M1LL;
        S_M1LL: state <= S_M1LH;
        S_M1LH: state <= S_M1HL;
        S_M1HL: state <= S_MID;
        S_MID:  state <= S_M2LL;
        S_M2LL: state <= S_M2LH;
        S_M2LH: state <= S_M2HL;
        S_M2HL: state <= S_POST;
        S_POST: begin
          second <= 1'b1;
          state  <= second ? S_CHECK : S_PRE;
        end
        S_STEP: begin
          if (stat.out_free) begin
            words_left <= words_left - WORD_W'(1);
            state      <= is_last ? S_IDLE : S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for random_byte_block_generator: an in-bench xorshift128+ and
// SplitMix64 predictor checks every word. Depends on rbbg_pkg, rbbg_if and the block RTL.
module testbench;
  import rbbg_pkg::*;

  // Run limits.
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off for back-pressure
  localparam int          MAX_WAIT     = 13;

  typedef struct packed {
    logic [WORD_DW-1:0]  random_word;
    logic [VBYTES_W-1:0] valid_bytes;
    logic                last_word;
  } word_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbbg_seed_if cfg_if ();
  rbbg_req_if  req_if ();
  rbbg_word_if rsp_if ();

  random_byte_block_generator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the seed register and the two halves of the generator.
  logic [63:0] seed_reg;
  logic [63:0] gen_lo;
  logic [63:0] gen_hi;

  // Byte counts waiting to be offered, and words the block still owes us.
  logic [COUNT_W-1:0] request_queue [$];
  word_result_t       pending_words [$];

  // Idling controls, set per phase by the sequencer; rsp_hold comes from the hold-off block.
  bit send_gaps_on;
  bit recv_stalls_on;
  bit pressure_phase;
  logic rsp_hold;

  int send_gap;
  int recv_stall;
  int mismatch_count;
  int unsigned cycle_count;

  int unsigned directed_counts [20] = '{0, 1, 7, 8, 9, 15, 16, 17, 63, 64, 65, 256,
                                        511, 512, 513, 768, 1023, 0, 2, 3};

  // One SplitMix64 output; advances the local accumulator.
  function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
    logic [63:0] z;
    acc = acc + GOLDEN_GAMMA;
    z = acc;
    z = (z ^ (z >> MIX_SH_1)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SH_2)) * MIX_MUL_B;
    return z ^ (z >> MIX_SH_3);
  endfunction

  // One xorshift128+ word; seed first whenever the whole state is zero.
  function automatic logic [63:0] xorshift_draw();
    logic [63:0] acc;
    logic [63:0] a;
    logic [63:0] b;
    if (gen_lo == '0 && gen_hi == '0) begin
      acc = seed_reg;
      gen_lo = splitmix_next(acc);
      gen_hi = splitmix_next(acc);
    end
    a = gen_lo;
    b = gen_hi;
    gen_lo = b;
    a = a ^ (a << XS_SH_A);
    gen_hi = a ^ b ^ (a >> XS_SH_B) ^ (b >> XS_SH_C);
    return gen_hi + b;
  endfunction

  // Queue every word one request should produce.
  function automatic void predict_words(input logic [COUNT_W-1:0] count);
    int unsigned nbytes;
    int unsigned nwords;
    int unsigned tail;
    word_result_t w;
    nbytes = 32'(count);
    if (nbytes == 0) return;
    if (nbytes > MAX_BYTES) nbytes = MAX_BYTES;
    nwords = (nbytes + 7) / 8;
    tail = nbytes % 8;
    if (tail == 0) tail = 8;
    for (int unsigned k = 0; k < nwords; k++) begin
      w.random_word = xorshift_draw();
      w.last_word   = (k + 1 == nwords);
      w.valid_bytes = w.last_word ? VBYTES_W'(tail) : FULL_WORD_BYTES;
      pending_words.push_back(w);
    end
  endfunction

  // Mostly short requests, with a share of long ones, of saturating counts and of zeros.
  function automatic logic [COUNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick <= 2) return COUNT_W'($urandom_range(MAX_BYTES + 1, (1 << COUNT_W) - 1));
    if (pick == 3) return COUNT_W'($urandom_range(65, MAX_BYTES));
    return COUNT_W'($urandom_range(1, 64));
  endfunction

  // Request driver: offer the next queued count, then hold off for a drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid      <= 1'b0;
      req_if.byte_count <= '0;
      send_gap          <= 0;
    end else begin
      // Predict at the edge where the transfer happens so that words stay in order.
      if (req_if.valid && req_if.ready)
        predict_words(req_if.byte_count);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          req_if.valid      <= 1'b1;
          req_if.byte_count <= request_queue.pop_front();
          send_gap          <= send_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Word monitor: check each transfer against the oldest expectation, then draw a stall.
  always @(posedge clk) begin
    word_result_t exp_w;
    int stall_next;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: word with nothing expected: expected none, actual %h/%0d/%0b",
                   $time, rsp_if.random_word, rsp_if.valid_bytes, rsp_if.last_word);
        end else begin
          exp_w = pending_words.pop_front();
          if (exp_w.random_word !== rsp_if.random_word) begin
            mismatch_count++;
            $display("%0t: random_word mismatch: expected %h, actual %h",
                     $time, exp_w.random_word, rsp_if.random_word);
          end
          if (exp_w.valid_bytes !== rsp_if.valid_bytes) begin
            mismatch_count++;
            $display("%0t: valid_bytes mismatch: expected %0d, actual %0d",
                     $time, exp_w.valid_bytes, rsp_if.valid_bytes);
          end
          if (exp_w.last_word !== rsp_if.last_word) begin
            mismatch_count++;
            $display("%0t: last_word mismatch: expected %0b, actual %0b",
                     $time, exp_w.last_word, rsp_if.last_word);
          end
        end
        stall_next = recv_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      end else begin
        stall_next = (recv_stall > 0) ? recv_stall - 1 : 0;
      end
      recv_stall   <= stall_next;
      // Drop ready while stalling or while the long hold-off is in force.
      rsp_if.ready <= !rsp_hold && stall_next == 0;
    end
  end

  // Long hold-off on the result side, counted here, while the sender keeps offering
  // back-to-back requests so that the block fills up and stalls its input.
  initial begin
    rsp_hold = 1'b0;
    wait (pressure_phase);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Write the seed register; only called while the block is idle.
  task automatic write_seed(input logic [63:0] value);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.seed_value <= value;
    do @(posedge clk); while (!cfg_if.ready);
    seed_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until nothing is queued, offered or owed, then let a zero-count request
  // that produced no words finish inside the block.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || req_if.valid || pending_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Queue counts on the falling edge, clear of the driver's pops.
  task automatic queue_random(input int n);
    @(negedge clk);
    repeat (n) request_queue.push_back(random_count());
  endtask

  // Sequencer: reset, then phases with different seeds and idling patterns.
  initial begin
    cfg_if.valid      = 1'b0;
    cfg_if.seed_value = '0;
    req_if.valid      = 1'b0;
    req_if.byte_count = '0;
    rsp_if.ready      = 1'b0;
    seed_reg          = '0;
    gen_lo            = '0;
    gen_hi            = '0;
    send_gaps_on      = 1'b1;
    recv_stalls_on    = 1'b1;
    pressure_phase    = 1'b0;
    mismatch_count    = 0;
    cycle_count       = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: all-ones seed (only the first draw after reset seeds the state);
    // a zero count before any draw must leave the state untouched.
    write_seed('1);
    @(negedge clk);
    foreach (directed_counts[i]) request_queue.push_back(COUNT_W'(directed_counts[i]));
    wait_idle();

    // Random with gaps on both sides; seed zero has no effect on a running generator.
    write_seed('0);
    queue_random(70);
    wait_idle();

    // Back-pressure: no sender gaps while the receiver holds off for a long stretch.
    write_seed({$urandom, $urandom});
    @(negedge clk);
    send_gaps_on   = 1'b0;
    pressure_phase = 1'b1;
    queue_random(40);
    wait_idle();

    // Full rate on both sides.
    write_seed({$urandom, $urandom});
    @(negedge clk);
    recv_stalls_on = 1'b0;
    queue_random(65);
    wait_idle();

    // Mixed idling again.
    write_seed({$urandom, $urandom});
    @(negedge clk);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    queue_random(65);
    wait_idle();

    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
